[rtl/hashed_key_set_direct_mapped_defines.svh]
// assertion macros for the hashed key set
`ifndef HASHED_KEY_SET_DIRECT_MAPPED_DEFINES_SVH
`define HASHED_KEY_SET_DIRECT_MAPPED_DEFINES_SVH

`ifndef SYNTH
`define HKS_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("hks assertion failed");
`define HKS_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("hks assertion failed");
`else
`define HKS_ASSERT_IMP(lbl, ck, rs, a, c)
`define HKS_ASSERT_NXT(lbl, ck, rs, a, c)
`endif

`endif

[rtl/hks_pkg.sv]
// shared types and constants for the hashed key set
`default_nettype none
package hks_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_BYTES_DEF   = 16;

  localparam logic [63:0] HASH_START = 64'd5381;
  localparam int          MUL_SHIFT  = 5;
  localparam logic [6:0]  TABLE_SIZE_RST = 7'd64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_VOID   = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_COLLISION = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_BYTE,
    S_DIV,
    S_SEL,
    S_CHK,
    S_CPRD,
    S_CPWR,
    S_CMPRD,
    S_CMPCHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       clr_step;
    logic       byte_take;
    logic       div_init;
    logic       div_step;
    logic       meta_rd;
    logic       meta_wr_ins;
    logic       meta_wr_del;
    logic       idx_clr;
    logic       idx_inc;
    logic       copy_rd;
    logic       copy_wr;
    logic       cmp_rd;
    logic       out_load;
    logic       key_done;
    logic [2:0] out_code;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       div_last;
    logic       too_long;
    logic       slot_valid;
    logic       len_match;
    logic       byte_eq;
    logic       idx_last;
    logic [1:0] op;
    logic       in_last;
    logic       in_void;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

[rtl/hks_ifs.sv]
// valid/ready channel interfaces for key bytes and results
`default_nettype none
interface hks_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] key_byte;
  logic       last;
  modport source (output valid, opcode, key_byte, last, input ready);
  modport sink (input valid, opcode, key_byte, last, output ready);
endinterface

interface hks_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [63:0] hash_value;
  modport source (output valid, status, slot, hash_value, input ready);
  modport sink (input valid, status, slot, hash_value, output ready);
endinterface
`default_nettype wire

[rtl/hashed_key_set_direct_mapped.sv]
// top level of the direct-mapped hashed key set
//
//   channel     dir  handshake      payload
//   key_in      in   valid/ready    opcode, key_byte, last
//   result_out  out  valid/ready    status, slot, hash_value
//   cfg         in   cfg_we         cfg_data (table_size)
//
// one key byte per cycle while key_in is ready; after the last byte a bit-serial modulo,
// then a slot lookup (read, check) plus a read and a write or check per key byte to copy or compare.
// after reset and after every table_size write a clearing pass
// runs over the slot table with key_in not ready.
// a result waits in the output register; a stalled result holds the next key.
`default_nettype none
`include "hashed_key_set_direct_mapped_defines.svh"
module hashed_key_set_direct_mapped #(
  parameter int TABLE_DEPTH = hks_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = hks_pkg::KEY_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_data,
  hks_in_if.sink          key_in,
  hks_out_if.source       result_out
);

  hks_pkg::cmd_t  cmd;
  hks_pkg::stat_t stat;
  logic           in_ready;

  assign key_in.ready = in_ready;

  hks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (key_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hks_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .opcode     (key_in.opcode),
    .key_byte   (key_in.key_byte),
    .last       (key_in.last),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_status (result_out.status),
    .out_slot   (result_out.slot),
    .out_hash   (result_out.hash_value)
  );

  `HKS_ASSERT_IMP(a_no_take_in_clear, clk, rst, cmd.clr_step, !key_in.ready)
  `HKS_ASSERT_IMP(a_load_when_free, clk, rst, cmd.out_load,
                  !result_out.valid || result_out.ready)
  `HKS_ASSERT_IMP(a_insert_empty_only, clk, rst, cmd.meta_wr_ins, !stat.slot_valid)
  `HKS_ASSERT_NXT(a_load_shows, clk, rst, cmd.out_load, result_out.valid)

endmodule
`default_nettype wire

[rtl/hks_ctrl.sv]
// controller state machine for the hashed key set
`default_nettype none
module hks_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hks_pkg::stat_t stat,
  output hks_pkg::cmd_t      cmd
);

  hks_pkg::state_t state, state_next;
  logic [2:0] code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hks_pkg::S_CLEAR;
      code  <= hks_pkg::ST_INSERTED;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    case (state)
      hks_pkg::S_CLEAR: begin
        if (stat.clr_last) state_next = hks_pkg::S_BYTE;
      end
      hks_pkg::S_BYTE: begin
        if (in_valid && stat.in_last && !stat.in_void) state_next = hks_pkg::S_DIV;
      end
      hks_pkg::S_DIV: begin
        if (stat.div_last) state_next = hks_pkg::S_SEL;
      end
      hks_pkg::S_SEL: begin
        if (stat.too_long) begin
          code_next  = hks_pkg::ST_TOO_LONG;
          state_next = hks_pkg::S_OUT;
        end else begin
          state_next = hks_pkg::S_CHK;
        end
      end
      hks_pkg::S_CHK: begin
        if (stat.op == hks_pkg::OP_INSERT) begin
          if (stat.slot_valid) begin
            code_next  = hks_pkg::ST_COLLISION;
            state_next = hks_pkg::S_OUT;
          end else begin
            state_next = hks_pkg::S_CPRD;
          end
        end else if (!stat.slot_valid || !stat.len_match) begin
          code_next  = hks_pkg::ST_NOT_FOUND;
          state_next = hks_pkg::S_OUT;
        end else begin
          state_next = hks_pkg::S_CMPRD;
        end
      end
      hks_pkg::S_CPRD: state_next = hks_pkg::S_CPWR;
      hks_pkg::S_CPWR: begin
        if (stat.idx_last) begin
          code_next  = hks_pkg::ST_INSERTED;
          state_next = hks_pkg::S_OUT;
        end else begin
          state_next = hks_pkg::S_CPRD;
        end
      end
      hks_pkg::S_CMPRD: state_next = hks_pkg::S_CMPCHK;
      hks_pkg::S_CMPCHK: begin
        if (!stat.byte_eq) begin
          code_next  = hks_pkg::ST_NOT_FOUND;
          state_next = hks_pkg::S_OUT;
        end else if (stat.idx_last) begin
          code_next  = (stat.op == hks_pkg::OP_REMOVE) ? hks_pkg::ST_REMOVED
                                                       : hks_pkg::ST_FOUND;
          state_next = hks_pkg::S_OUT;
        end else begin
          state_next = hks_pkg::S_CMPRD;
        end
      end
      hks_pkg::S_OUT: begin
        if (stat.out_free) state_next = hks_pkg::S_BYTE;
      end
      default: state_next = hks_pkg::S_CLEAR;
    endcase
    // table size write restarts the clearing pass
    if (cfg_we) state_next = hks_pkg::S_CLEAR;
  end

  always_comb begin
    cmd          = '0;
    cmd.out_code = code;
    in_ready     = 1'b0;
    case (state)
      hks_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      hks_pkg::S_BYTE: begin
        in_ready      = 1'b1;
        cmd.byte_take = in_valid;
        cmd.div_init  = in_valid && stat.in_last && !stat.in_void;
      end
      hks_pkg::S_DIV: cmd.div_step = 1'b1;
      hks_pkg::S_SEL: begin
        cmd.meta_rd = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      hks_pkg::S_CHK: begin
        cmd.meta_wr_ins = (stat.op == hks_pkg::OP_INSERT) && !stat.slot_valid;
      end
      hks_pkg::S_CPRD: cmd.copy_rd = 1'b1;
      hks_pkg::S_CPWR: begin
        cmd.copy_wr = 1'b1;
        cmd.idx_inc = !stat.idx_last;
      end
      hks_pkg::S_CMPRD: cmd.cmp_rd = 1'b1;
      hks_pkg::S_CMPCHK: begin
        cmd.idx_inc     = stat.byte_eq && !stat.idx_last;
        cmd.meta_wr_del = stat.byte_eq && stat.idx_last && (stat.op == hks_pkg::OP_REMOVE);
      end
      hks_pkg::S_OUT: begin
        cmd.out_load = stat.out_free;
        cmd.key_done = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/hks_dp.sv]
// datapath: running hash, key buffer, serial modulo, slot tables, result register
`default_nettype none
module hks_dp #(
  parameter int TABLE_DEPTH = hks_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = hks_pkg::KEY_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [6:0]     cfg_data,
  input  wire logic [1:0]     opcode,
  input  wire logic [7:0]     key_byte,
  input  wire logic           last,
  input  wire hks_pkg::cmd_t  cmd,
  output hks_pkg::stat_t      stat,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          out_status,
  output logic [5:0]          out_slot,
  output logic [63:0]         out_hash
);

  localparam int SLOT_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IDX_W   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int LEN_W   = $clog2(KEY_BYTES + 2);
  localparam int KDEPTH  = TABLE_DEPTH * KEY_BYTES;
  localparam int KADDR_W = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int META_W  = LEN_W + 1;

  logic [6:0]         table_size;
  logic [6:0]         eff_size;
  logic [63:0]        running_hash, hash_next, hkey;
  logic [LEN_W-1:0]   len;
  logic [1:0]         op_q;
  logic [7:0]         inbuf [KEY_BYTES];
  logic [7:0]         inbuf_q;
  logic [63:0]        dvd;
  logic [6:0]         rem, rem_next;
  logic [7:0]         trial;
  logic [5:0]         dcnt;
  logic [SLOT_W-1:0]  slot, clr_cnt;
  logic [META_W-1:0]  meta [TABLE_DEPTH];
  logic [META_W-1:0]  meta_q;
  logic [7:0]         keymem [KDEPTH];
  logic [7:0]         key_q;
  logic [IDX_W-1:0]   idx;
  logic [KADDR_W-1:0] kaddr;

  always_comb begin
    if (table_size == 7'd0) eff_size = 7'd1;
    else if (32'(table_size) > TABLE_DEPTH) eff_size = 7'(TABLE_DEPTH);
    else eff_size = table_size;
  end

  assign hash_next = ((running_hash << hks_pkg::MUL_SHIFT) + running_hash)
                     ^ {{56{key_byte[7]}}, key_byte};
  assign trial     = {rem, dvd[63]};
  assign rem_next  = (trial >= {1'b0, eff_size}) ? 7'(trial - {1'b0, eff_size}) : trial[6:0];
  assign slot      = SLOT_W'(rem);
  assign kaddr     = KADDR_W'(32'(slot) * KEY_BYTES) + KADDR_W'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= hks_pkg::TABLE_SIZE_RST;
      running_hash <= hks_pkg::HASH_START;
      len          <= '0;
      clr_cnt      <= '0;
    end else begin
      if (cfg_we) table_size <= cfg_data;
      if (cfg_we) clr_cnt <= '0;
      else if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.byte_take) begin
        if (last) running_hash <= hks_pkg::HASH_START;
        else running_hash <= hash_next;
        if (last && opcode == hks_pkg::OP_VOID) len <= '0;
        else if (len <= LEN_W'(KEY_BYTES)) len <= len + 1'b1;
      end else if (cmd.key_done) begin
        len <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_take && len < LEN_W'(KEY_BYTES)) inbuf[len[IDX_W-1:0]] <= key_byte;
    if (cmd.byte_take && last) begin
      hkey <= hash_next;
      op_q <= opcode;
    end
    if (cmd.div_init) begin
      dvd  <= hash_next;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dvd  <= dvd << 1;
      rem  <= rem_next;
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.idx_clr) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
    if (cmd.copy_rd || cmd.cmp_rd) inbuf_q <= inbuf[idx];
  end

  // slot length and valid table
  always_ff @(posedge clk) begin
    if (cmd.clr_step) meta[clr_cnt] <= '0;
    else if (cmd.meta_wr_ins) meta[slot] <= {1'b1, len};
    else if (cmd.meta_wr_del) meta[slot] <= {1'b0, len};
    if (cmd.meta_rd) meta_q <= meta[slot];
  end

  // stored key bytes
  always_ff @(posedge clk) begin
    if (cmd.copy_wr) keymem[kaddr] <= inbuf_q;
    if (cmd.cmp_rd) key_q <= keymem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_code;
      out_slot   <= rem[5:0];
      out_hash   <= hkey;
    end
  end

  always_comb begin
    stat.clr_last   = (clr_cnt == SLOT_W'(TABLE_DEPTH - 1)) && !cfg_we;
    stat.div_last   = (dcnt == 6'd63);
    stat.too_long   = (len > LEN_W'(KEY_BYTES));
    stat.slot_valid = meta_q[META_W-1];
    stat.len_match  = (meta_q[LEN_W-1:0] == len);
    stat.byte_eq    = (inbuf_q == key_q);
    stat.idx_last   = ((LEN_W'(idx) + LEN_W'(1)) == len);
    stat.op         = op_q;
    stat.in_last    = last;
    stat.in_void    = (opcode == hks_pkg::OP_VOID);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

[sim/tb_hks_scoreboard.sv]
// scoreboard for the hashed key set: predicts results and checks them
`timescale 1ns / 100ps
`default_nettype none
package tb_hks_sb_pkg;
  import hks_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [63:0] hash_value;
  } lookup_t;

  class key_set_scoreboard;
    logic [6:0]  size_reg;
    logic [63:0] acc_hash;
    logic [7:0]  cur_key [16];
    int          cur_len;
    bit          occupied [64];
    int          stored_len [64];
    logic [7:0]  stored_key [64][16];
    lookup_t     pending [$];
    int          errors;

    function new();
      errors = 0;
      size_reg = TABLE_SIZE_RST;
      acc_hash = HASH_START;
      cur_len = 0;
      foreach (occupied[i]) occupied[i] = 0;
    endfunction

    function void set_size(logic [6:0] v);
      size_reg = v;
      foreach (occupied[i]) occupied[i] = 0;
    endfunction

    function bit same_key(int s);
      if (!occupied[s] || stored_len[s] != cur_len) return 0;
      for (int i = 0; i < cur_len; i++)
        if (stored_key[s][i] != cur_key[i]) return 0;
      return 1;
    endfunction

    function void note_byte(logic [1:0] op, logic [7:0] b, logic lst);
      logic [63:0] ext;
      int          modn;
      int          s;
      lookup_t     r;
      ext = {{56{b[7]}}, b};
      acc_hash = ((acc_hash << MUL_SHIFT) + acc_hash) ^ ext;
      if (cur_len < 16) cur_key[cur_len] = b;
      if (cur_len <= 16) cur_len++;
      if (!lst) return;
      modn = (size_reg == 0) ? 1 : (size_reg > 64) ? 64 : size_reg;
      s = int'(acc_hash % 64'(modn));
      r.slot = s[5:0];
      r.hash_value = acc_hash;
      if (op != OP_VOID) begin
        if (cur_len > 16) r.status = ST_TOO_LONG;
        else if (op == OP_INSERT) begin
          if (occupied[s]) r.status = ST_COLLISION;
          else begin
            occupied[s] = 1;
            stored_len[s] = cur_len;
            for (int i = 0; i < cur_len; i++) stored_key[s][i] = cur_key[i];
            r.status = ST_INSERTED;
          end
        end else if (op == OP_FIND) r.status = same_key(s) ? ST_FOUND : ST_NOT_FOUND;
        else if (same_key(s)) begin
          occupied[s] = 0;
          r.status = ST_REMOVED;
        end else r.status = ST_NOT_FOUND;
        pending.push_back(r);
      end
      acc_hash = HASH_START;
      cur_len = 0;
    endfunction

    function void check_result(lookup_t got);
      lookup_t exp;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status)
        $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
      if (got.slot != exp.slot)
        $display("%0t slot exp %0d got %0d", $time, exp.slot, got.slot);
      if (got.hash_value != exp.hash_value)
        $display("%0t hash exp %h got %h", $time, exp.hash_value, got.hash_value);
      if (got != exp) errors++;
    endfunction
  endclass
endpackage
`default_nettype wire

[sim/tb.sv]
// testbench top: drives keys and table sizes into the hashed key set
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import hks_pkg::*;
  import tb_hks_sb_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [6:0] cfg_data;
  hks_in_if   key_in ();
  hks_out_if  result_out ();

  hashed_key_set_direct_mapped u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .key_in(key_in.sink), .result_out(result_out.source)
  );

  key_set_scoreboard sb;
  int  idle_pct;
  int  hold_cycles;
  logic [7:0] pool [8][18];
  int         pool_len [8];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && key_in.valid && key_in.ready)
      sb.note_byte(key_in.opcode, key_in.key_byte, key_in.last);
    if (!rst && result_out.valid && result_out.ready)
      sb.check_result({result_out.status, result_out.slot, result_out.hash_value});
  end

  initial begin
    result_out.ready = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_out.ready <= 0;
        hold_cycles--;
      end else
        result_out.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // valid stays up after a transfer until the next byte or an idle cycle
  task automatic send_byte(logic [1:0] op, logic [7:0] b, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      key_in.valid <= 0;
      @(negedge clk);
    end
    key_in.valid <= 1;
    key_in.opcode <= op;
    key_in.key_byte <= b;
    key_in.last <= lst;
    do @(posedge clk); while (!key_in.ready);
    @(negedge clk);
  endtask

  task automatic send_key(logic [1:0] op, int n, logic [7:0] fill, bit rnd);
    for (int i = 0; i < n; i++)
      send_byte((rnd && i != n - 1) ? 2'($urandom_range(2)) : op,
                rnd ? 8'($urandom) : fill, i == n - 1);
    // keep opcode of last byte
  endtask

  task automatic send_pool_key(logic [1:0] op, int k);
    for (int i = 0; i < pool_len[k]; i++)
      send_byte(op, pool[k][i], i == pool_len[k] - 1);
  endtask

  task automatic drain();
    key_in.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_size(logic [6:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_size(v);
  endtask

  initial begin
    int r;
    sb = new();
    idle_pct = 36;
    hold_cycles = 0;
    rst = 1;
    cfg_we = 0;
    cfg_data = 0;
    key_in.valid = 0;
    key_in.opcode = OP_INSERT;
    key_in.key_byte = 0;
    key_in.last = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_key(OP_INSERT, 1, 8'h00, 0);
    send_key(OP_INSERT, 1, 8'h00, 0);
    send_key(OP_FIND, 1, 8'h00, 0);
    send_key(OP_REMOVE, 1, 8'h00, 0);
    send_key(OP_REMOVE, 1, 8'h00, 0);
    send_key(OP_FIND, 1, 8'h00, 0);
    send_key(OP_INSERT, 16, 8'hff, 0);
    send_key(OP_FIND, 16, 8'hff, 0);
    send_key(OP_FIND, 17, 8'hff, 0);
    send_key(OP_REMOVE, 20, 8'h80, 0);
    send_key(OP_VOID, 3, 8'h7f, 0);
    send_key(OP_FIND, 2, 8'h55, 0);
    send_byte(OP_FIND, 8'haa, 0);
    send_byte(OP_INSERT, 8'h33, 1);
    write_size(7'd1);
    send_key(OP_INSERT, 2, 8'h12, 0);
    send_key(OP_INSERT, 3, 8'h34, 0);
    send_key(OP_REMOVE, 3, 8'h34, 0);
    write_size(7'd0);
    send_key(OP_INSERT, 4, 8'h01, 0);
    write_size(7'd127);
    send_key(OP_INSERT, 4, 8'h01, 0);

    for (int phase = 0; phase < 4; phase++) begin
      write_size(phase == 0 ? 7'd64 : phase == 1 ? 7'd5 :
                 7'($urandom_range(127)));
      for (int k = 0; k < 8; k++) begin
        pool_len[k] = ($urandom_range(9) == 0) ? $urandom_range(1, 18)
                                               : $urandom_range(1, 4);
        for (int i = 0; i < 18; i++) pool[k][i] = 8'($urandom);
      end
      idle_pct = (phase == 2) ? 0 : 36;
      if (phase == 1) hold_cycles = 400;
      for (int n = 0; n < 50; n++) begin
        r = $urandom_range(9);
        if (r < 8) send_pool_key(2'($urandom_range(2)), $urandom_range(7));
        else if (r == 8) send_key(OP_VOID, $urandom_range(1, 3), 0, 1);
        else send_key(OP_INSERT, $urandom_range(1, 5), 0, 1);
        if (phase == 3 && n == 30) drain();
      end
    end
    idle_pct = 36;
    drain();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
